// ===== rtl/core/atrp_pkg.sv =====
// atrp_pkg: shared types and constants for the relocation patcher pipeline
// used by every module under rtl/core; depends on nothing else
`default_nettype none

package atrp_pkg;

   // relocation type codes on the request channel
   localparam logic [7:0] RELOC_ABS32    = 8'd2;
   localparam logic [7:0] RELOC_THM_CALL = 8'd10;
   localparam logic [7:0] RELOC_MOVW     = 8'd47;
   localparam logic [7:0] RELOC_MOVT     = 8'd48;

   // status codes on the result channel
   localparam logic STATUS_OK          = 1'b0;
   localparam logic STATUS_UNSUPPORTED = 1'b1;

   // bl pair prefixes in bits 15:11 of each halfword
   localparam logic [4:0] BL_HI_PREFIX = 5'b11110;
   localparam logic [4:0] BL_LO_PREFIX = 5'b11111;

   // decoded operation carried down the pipe
   typedef enum logic [2:0] {
      KIND_ABS32,
      KIND_CALL,
      KIND_MOVW,
      KIND_MOVT,
      KIND_UNSUP
   } kind_type;

   // payload after decode
   typedef struct packed {
      kind_type    kind;
      logic [31:0] orig;
      logic [31:0] sym;
      logic [31:0] place;
      logic        thumb;
      logic [31:0] addend;
   } dec_type;

   // payload after the symbol add
   typedef struct packed {
      kind_type    kind;
      logic [31:0] orig;
      logic [31:0] place;
      logic [31:0] sum;
   } sum_type;

endpackage

`default_nettype wire

// ===== rtl/core/atrp_decode.sv =====
// atrp_decode: first stage, classifies the type and extracts the addend
// depends on atrp_pkg
`default_nettype none

module atrp_decode (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  wire  [7:0]           reloc_type,
   input  wire  [31:0]          orig_word,
   input  wire  [31:0]          symbol_addr,
   input  wire  [31:0]          place_addr,
   input  wire                  symbol_is_func,
   output logic                 out_valid,
   input  wire                  out_ready,
   output atrp_pkg::dec_type    out_data
);
   import atrp_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   dec_type     data_ff;
   dec_type     data_in;
   logic [15:0] hw0;
   logic [15:0] hw1;
   logic [15:0] imm16;

   // stage advances when empty or downstream takes the transaction
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign valid_in  = in_ready ? in_valid : valid_ff;

   assign hw0   = orig_word[15:0];
   assign hw1   = orig_word[31:16];
   assign imm16 = {hw0[3:0], hw0[10], hw1[14:12], hw1[7:0]};

   // type decode and addend extraction
   always_comb begin
      data_in.orig  = orig_word;
      data_in.sym   = symbol_addr;
      data_in.place = place_addr;
      data_in.thumb = symbol_is_func;
      case (reloc_type)
         RELOC_ABS32: begin
            data_in.kind   = KIND_ABS32;
            data_in.addend = orig_word;
         end
         RELOC_THM_CALL: begin
            data_in.kind   = KIND_CALL;
            data_in.addend = {{9{hw0[10]}}, hw0[10:0], hw1[10:0], 1'b0};
         end
         RELOC_MOVW: begin
            data_in.kind   = KIND_MOVW;
            data_in.addend = {{16{imm16[15]}}, imm16};
         end
         RELOC_MOVT: begin
            data_in.kind   = KIND_MOVT;
            data_in.addend = {{16{imm16[15]}}, imm16};
         end
         default: begin
            data_in.kind   = KIND_UNSUP;
            data_in.addend = 32'd0;
         end
      endcase
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/atrp_add.sv =====
// atrp_add: second stage, adds symbol and addend and merges the thumb bit
// depends on atrp_pkg
`default_nettype none

module atrp_add (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  atrp_pkg::dec_type    in_data,
   output logic                 out_valid,
   input  wire                  out_ready,
   output atrp_pkg::sum_type    out_data
);
   import atrp_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   sum_type     data_ff;
   sum_type     data_in;
   logic [31:0] raw_sum;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign valid_in  = in_ready ? in_valid : valid_ff;

   assign raw_sum = in_data.sym + in_data.addend;

   // s + a, with t or-ed in for calls and movw
   always_comb begin
      data_in.kind  = in_data.kind;
      data_in.orig  = in_data.orig;
      data_in.place = in_data.place;
      case (in_data.kind)
         KIND_CALL, KIND_MOVW: data_in.sum = {raw_sum[31:1], raw_sum[0] | in_data.thumb};
         default:              data_in.sum = raw_sum;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/atrp_encode.sv =====
// atrp_encode: last stage, subtracts the place for calls and re-encodes the word
// depends on atrp_pkg; its registers drive the result channel
`default_nettype none

module atrp_encode (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  atrp_pkg::sum_type    in_data,
   output logic                 out_valid,
   input  wire                  out_ready,
   output logic [31:0]          patched_word,
   output logic                 status
);
   import atrp_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   logic [31:0] word_ff;
   logic [31:0] word_in;
   logic        status_ff;
   logic        status_in;
   logic [31:0] branch;
   logic [15:0] field;
   logic [15:0] hw0;
   logic [15:0] hw1;

   assign in_ready     = !valid_ff || out_ready;
   assign out_valid    = valid_ff;
   assign patched_word = word_ff;
   assign status       = status_ff;
   assign valid_in     = in_ready ? in_valid : valid_ff;

   assign branch = in_data.sum - in_data.place;
   assign field  = (in_data.kind == KIND_MOVT) ? in_data.sum[31:16] : in_data.sum[15:0];
   assign hw0    = in_data.orig[15:0];
   assign hw1    = in_data.orig[31:16];

   // word assembly per operation
   always_comb begin
      status_in = STATUS_OK;
      case (in_data.kind)
         KIND_ABS32: word_in = in_data.sum;
         KIND_CALL: begin
            word_in = {BL_LO_PREFIX, branch[11:1], BL_HI_PREFIX, branch[22:12]};
         end
         KIND_MOVW, KIND_MOVT: begin
            word_in = {hw1[15], field[10:8], hw1[11:8], field[7:0],
                       hw0[15:11], field[11], hw0[9:4], field[15:12]};
         end
         default: begin
            word_in   = in_data.orig;
            status_in = STATUS_UNSUPPORTED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         word_ff   <= word_in;
         status_ff <= status_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/arm_thumb_relocation_patcher.sv =====
// relocation patcher: one request in, one patched word out, through three stages
// ports of the decode, add and encode stages; types from atrp_pkg
//
// usage:
//   req_* carries one relocation transaction: type, original word, symbol
//   address, place address and the function flag. rsp_* returns the patched
//   word and a status (1 when the type is not abs32, thm_call, movw or movt).
//   a transaction moves on each edge where valid and ready are both high.
// pipeline and throughput:
//   decode, symbol add and place subtract/encode each hold one register
//   stage, in that order; the encode register drives rsp_valid. with
//   rsp_ready held high one transaction enters and one leaves every cycle.
// stall:
//   when rsp_ready is low the last stage holds its result and each stage keeps
//   accepting until it and the one below it are full; then req_ready drops.
//   nothing is dropped or repeated.
// reset:
//   synchronous, active high; empties all stages, rsp_valid is low after it.
`default_nettype none

module arm_thumb_relocation_patcher (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_ready,
   input  wire  [7:0]   req_reloc_type,
   input  wire  [31:0]  req_orig_word,
   input  wire  [31:0]  req_symbol_addr,
   input  wire  [31:0]  req_place_addr,
   input  wire          req_symbol_is_func,
   output logic         rsp_valid,
   input  wire          rsp_ready,
   output logic [31:0]  rsp_patched_word,
   output logic         rsp_status
);
   import atrp_pkg::*;

   logic    dec_valid;
   logic    dec_ready;
   dec_type dec_data;
   logic    sum_valid;
   logic    sum_ready;
   sum_type sum_data;

   // decode stage
   atrp_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_valid),
      .in_ready       (req_ready),
      .reloc_type     (req_reloc_type),
      .orig_word      (req_orig_word),
      .symbol_addr    (req_symbol_addr),
      .place_addr     (req_place_addr),
      .symbol_is_func (req_symbol_is_func),
      .out_valid      (dec_valid),
      .out_ready      (dec_ready),
      .out_data       (dec_data)
   );

   // symbol add stage
   atrp_add u_add (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_data  (sum_data)
   );

   // encode stage, drives the result channel
   atrp_encode u_encode (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (sum_valid),
      .in_ready     (sum_ready),
      .in_data      (sum_data),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .patched_word (rsp_patched_word),
      .status       (rsp_status)
   );

`ifndef SYNTHESIS
   // pipeline comes up empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid && !dec_valid)
      else $error("pipeline not empty after reset");

   // a free receiver never backs up the request side
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("req_ready low while rsp_ready high");

   // an accepted request lands in the decode register
   a_decode_fill: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> dec_valid)
      else $error("accepted transaction lost at decode");

   // a full middle stage that is stalled keeps its transaction
   a_add_hold: assert property (@(posedge clock) disable iff (reset)
      sum_valid && !sum_ready |=> sum_valid && $stable(sum_data))
      else $error("stalled add stage changed");
`endif

endmodule

`default_nettype wire
